/* rtl/core/sspmv_pkg.sv */
// ----------------------------------------------------------------------------
// sspmv_pkg
// shared constants and codes for the seven-point stencil spmv block
// ----------------------------------------------------------------------------
package sspmv_pkg;

    // defaults for the top-level parameters
    localparam int DEF_MAX_SLICE   = 4096;
    localparam int DEF_VALUE_WIDTH = 32;

    // fixed field widths
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 1;
    localparam int DIAG_W    = 3;
    localparam int FLAG_W    = 3;
    localparam int PROD_W    = 36;

    // history entry: value, diagonal, forward flags x/y/z
    localparam int DEF_HIST_DEPTH = 2 * DEF_MAX_SLICE + 1;
    localparam int DEF_ENT_W      = DEF_VALUE_WIDTH + DIAG_W + FLAG_W;

    localparam logic [CFG_W-1:0] RESET_ROW_LENGTH = CFG_W'(16);
    localparam logic [CFG_W-1:0] RESET_SLICE_SIZE = CFG_W'(256);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROW_LENGTH = 1'b0,
        REG_SLICE_SIZE = 1'b1
    } t_reg_idx;

    typedef enum logic [0:0] {
        MODE_VOXEL = 1'b0,
        MODE_FLUSH = 1'b1
    } t_mode;

endpackage

/* rtl/core/sspmv_in_if.sv */
// ----------------------------------------------------------------------------
// sspmv_in_if
// voxel input channel: valid/ready with one voxel or flush item
// ----------------------------------------------------------------------------
interface sspmv_in_if #(
    parameter int VALUE_WIDTH = sspmv_pkg::DEF_VALUE_WIDTH
) ();
    import sspmv_pkg::*;

    logic                    valid;
    logic                    ready;
    logic                    mode;
    logic signed [VALUE_WIDTH-1:0] vector_value;
    logic [DIAG_W-1:0]       diag_coef;
    logic signed [0:0]       coef_plus_x;
    logic signed [0:0]       coef_plus_y;
    logic signed [0:0]       coef_plus_z;

    modport source (
        output valid, mode, vector_value, diag_coef, coef_plus_x, coef_plus_y, coef_plus_z,
        input  ready
    );

    modport sink (
        input  valid, mode, vector_value, diag_coef, coef_plus_x, coef_plus_y, coef_plus_z,
        output ready
    );

endinterface

/* rtl/core/sspmv_out_if.sv */
// ----------------------------------------------------------------------------
// sspmv_out_if
// result channel: valid/ready with one product item
// ----------------------------------------------------------------------------
interface sspmv_out_if ();
    import sspmv_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [PROD_W-1:0] product_value;
    logic                     last_voxel;

    modport source (
        output valid, product_value, last_voxel,
        input  ready
    );

    modport sink (
        input  valid, product_value, last_voxel,
        output ready
    );

endinterface

/* rtl/core/sspmv_hist_ram.sv */
// ----------------------------------------------------------------------------
// sspmv_hist_ram
// voxel history memory: one write port, two registered read ports
// ----------------------------------------------------------------------------
module sspmv_hist_ram #(
    parameter int DEPTH = sspmv_pkg::DEF_HIST_DEPTH,
    parameter int WIDTH = sspmv_pkg::DEF_ENT_W
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);
    import sspmv_pkg::*;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_a;
    logic [WIDTH-1:0] r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read during write returns the old entry
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rd_a <= r_mem[i_raddr_a];
            r_rd_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rd_a;
    assign o_rdata_b = r_rd_b;

endmodule

/* rtl/core/seven_point_stencil_spmv.sv */
// Pipeline: results pass through stage b, stage c and the output register in turn.
// Throughput: one item per cycle unless the output stalls; the centre voxel and five taps come
// from three history memory copies, each with one write and two registered reads per cycle.
// Reset: synchronous, active low; clears counters, pointers and pipeline valids and sets
// row_length to 16 and slice_size to 256. History contents are not cleared.
// ----------------------------------------------------------------------------
// seven_point_stencil_spmv
// streaming seven-point stencil matrix-vector product over a voxel volume
// ----------------------------------------------------------------------------
module seven_point_stencil_spmv #(
    parameter int MAX_SLICE   = sspmv_pkg::DEF_MAX_SLICE,
    parameter int VALUE_WIDTH = sspmv_pkg::DEF_VALUE_WIDTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    sspmv_in_if.sink                          i_vox,
    sspmv_out_if.source                       o_res,
    input  logic                              i_cfg_we,
    input  logic [sspmv_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [sspmv_pkg::CFG_W-1:0]       i_cfg_data
);
    import sspmv_pkg::*;

    localparam int DEPTH  = 2 * MAX_SLICE + 1;
    localparam int AW     = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(MAX_SLICE + 1);
    localparam int CMP_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int ENT_W  = VALUE_WIDTH + DIAG_W + FLAG_W;
    localparam int POS_NX = 2;
    localparam int POS_NY = 1;
    localparam int POS_NZ = 0;

    typedef struct packed {
        logic xf;   // forward x neighbor inside volume
        logic xf0;  // forward x neighbor is the newest voxel
        logic yf;
        logic yf0;
        logic zf;   // forward z neighbor, always the newest voxel
        logic xb;   // backward neighbors inside volume
        logic yb;
        logic zb;
    } t_tap_flags;

    localparam logic [CNT_W-1:0] ONE = CNT_W'(1);

    // ------------------------------------------------------------------
    // helpers
    // ------------------------------------------------------------------
    function automatic logic [AW-1:0] ptr_add(input logic [AW-1:0] p,
                                              input logic [CNT_W-1:0] o);
        logic [AW:0] s;
        s = {1'b0, p} + (AW+1)'(o);
        if (s >= (AW+1)'(DEPTH)) begin
            s = s - (AW+1)'(DEPTH);
        end
        return s[AW-1:0];
    endfunction

    function automatic logic [AW-1:0] ptr_sub(input logic [AW-1:0] p,
                                              input logic [CNT_W-1:0] o);
        logic [AW:0] d;
        d = {1'b0, p} - (AW+1)'(o);
        if (d[AW]) begin
            d = d + (AW+1)'(DEPTH);
        end
        return d[AW-1:0];
    endfunction

    function automatic logic [PROD_W-1:0] ext(input logic [VALUE_WIDTH-1:0] v);
        return PROD_W'($signed(v));
    endfunction

    function automatic logic [VALUE_WIDTH-1:0] ent_val(input logic [ENT_W-1:0] e);
        return e[ENT_W-1 -: VALUE_WIDTH];
    endfunction

    // ------------------------------------------------------------------
    // state
    // ------------------------------------------------------------------
    logic [CFG_W-1:0]  r_row_len;
    logic [CFG_W-1:0]  r_slice;
    logic [CNT_W-1:0]  r_pending, n_pending;
    logic [CNT_W-1:0]  r_older, n_older;    // volume voxels older than the head
    logic [AW-1:0]     r_head, n_head;      // oldest voxel whose result is owed
    logic [AW-1:0]     r_wp, n_wp;
    logic              r_draining, n_draining;
    logic [VALUE_WIDTH-1:0] r_newest;

    logic [CNT_W-1:0]  eff_s, eff_r;
    logic [CMP_W-1:0]  s_wide, r_wide;
    logic              in_fire, is_flush, write_vox, give_flush, give_vox, n_give;
    logic [CNT_W-1:0]  t_dist, older_inc;
    logic [AW-1:0]     wp_next, head_next;
    t_tap_flags        n_flags;
    logic [ENT_W-1:0]  in_entry;

    logic              en_b, en_c, en_out;

    // stage b
    logic              r_b_valid;
    logic              r_b_last;
    t_tap_flags        r_b_f;
    logic [VALUE_WIDTH-1:0] r_b_near0;
    logic [ENT_W-1:0]  rd_center, rd_xb, rd_xf, rd_yb, rd_yf, rd_zb;

    // stage c
    logic              r_c_valid;
    logic              r_c_last;
    logic [PROD_W-1:0] r_c_prod, r_c_s1, r_c_s2;
    logic [PROD_W-1:0] n_c_prod, n_c_s1, n_c_s2;
    logic [PROD_W-1:0] term_xf, term_yf, term_zf, term_xb, term_yb, term_zb;

    // output register
    logic              r_out_valid;
    logic              r_out_last;
    logic [PROD_W-1:0] r_out_prod;

    // ------------------------------------------------------------------
    // effective geometry
    // ------------------------------------------------------------------
    always_comb begin
        s_wide = CMP_W'(r_slice);
        if (s_wide == '0) begin
            eff_s = ONE;
        end else if (s_wide > CMP_W'(MAX_SLICE)) begin
            eff_s = CNT_W'(MAX_SLICE);
        end else begin
            eff_s = CNT_W'(s_wide);
        end
        r_wide = CMP_W'(r_row_len);
        if (r_wide == '0) begin
            eff_r = ONE;
        end else if (r_wide > CMP_W'(eff_s)) begin
            eff_r = eff_s;
        end else begin
            eff_r = CNT_W'(r_wide);
        end
    end

    // ------------------------------------------------------------------
    // accept side
    // ------------------------------------------------------------------
    assign en_out = !r_out_valid || o_res.ready;
    assign en_c   = !r_c_valid || en_out;
    assign en_b   = !r_b_valid || en_c;

    assign i_vox.ready = en_b;
    assign in_fire     = i_vox.valid && i_vox.ready;
    assign is_flush    = (i_vox.mode == MODE_FLUSH);
    assign write_vox   = !is_flush && !r_draining;
    assign give_flush  = is_flush && (r_pending != '0);
    assign give_vox    = write_vox && (r_pending >= eff_s);
    assign n_give      = give_flush || give_vox;

    // distance from the newest stored voxel to the head
    assign t_dist    = is_flush ? (r_pending - ONE) : r_pending;
    assign older_inc = (&r_older) ? r_older : (r_older + ONE);
    assign wp_next   = (r_wp == AW'(DEPTH - 1)) ? '0 : (r_wp + AW'(1));
    assign head_next = (r_head == AW'(DEPTH - 1)) ? '0 : (r_head + AW'(1));

    assign in_entry = {i_vox.vector_value, i_vox.diag_coef,
                       i_vox.coef_plus_x, i_vox.coef_plus_y, i_vox.coef_plus_z};

    always_comb begin
        n_flags.xf  = (t_dist != '0);
        n_flags.xf0 = (t_dist == ONE);
        n_flags.yf  = (t_dist >= eff_r);
        n_flags.yf0 = (t_dist == eff_r);
        n_flags.zf  = (t_dist >= eff_s);
        n_flags.xb  = (r_older != '0);
        n_flags.yb  = (r_older >= eff_r);
        n_flags.zb  = (r_older >= eff_s);
    end

    always_comb begin
        n_pending  = r_pending;
        n_head     = r_head;
        n_wp       = r_wp;
        n_older    = r_older;
        n_draining = r_draining;
        if (in_fire) begin
            if (is_flush) begin
                if (r_pending == '0) begin
                    n_draining = 1'b0;
                end else if (r_pending == ONE) begin
                    // final result of the volume
                    n_pending  = '0;
                    n_older    = '0;
                    n_draining = 1'b0;
                    n_head     = head_next;
                end else begin
                    n_pending  = r_pending - ONE;
                    n_older    = older_inc;
                    n_draining = 1'b1;
                    n_head     = head_next;
                end
            end else if (!r_draining) begin
                n_wp = wp_next;
                if (r_pending < eff_s) begin
                    n_pending = r_pending + ONE;
                    if (r_pending == '0) begin
                        n_head  = wp_next;
                        n_older = '0;
                    end
                end else begin
                    n_head  = head_next;
                    n_older = older_inc;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_len  <= RESET_ROW_LENGTH;
            r_slice    <= RESET_SLICE_SIZE;
            r_pending  <= '0;
            r_older    <= '0;
            r_head     <= '0;
            r_wp       <= '0;
            r_draining <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (t_reg_idx'(i_cfg_idx))
                    REG_ROW_LENGTH: r_row_len <= i_cfg_data;
                    REG_SLICE_SIZE: r_slice   <= i_cfg_data;
                endcase
            end
            r_pending  <= n_pending;
            r_older    <= n_older;
            r_head     <= n_head;
            r_wp       <= n_wp;
            r_draining <= n_draining;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire && write_vox) begin
            r_newest <= i_vox.vector_value;
        end
    end

    // ------------------------------------------------------------------
    // history copies, one per pair of reads
    // ------------------------------------------------------------------
    sspmv_hist_ram #(
        .DEPTH (DEPTH),
        .WIDTH (ENT_W)
    ) u_ram_c (
        .i_clk     (i_clk),
        .i_we      (in_fire && write_vox),
        .i_waddr   (wp_next),
        .i_wdata   (in_entry),
        .i_re      (en_b),
        .i_raddr_a (r_head),
        .i_raddr_b (ptr_sub(r_head, ONE)),
        .o_rdata_a (rd_center),
        .o_rdata_b (rd_xb)
    );

    sspmv_hist_ram #(
        .DEPTH (DEPTH),
        .WIDTH (ENT_W)
    ) u_ram_x (
        .i_clk     (i_clk),
        .i_we      (in_fire && write_vox),
        .i_waddr   (wp_next),
        .i_wdata   (in_entry),
        .i_re      (en_b),
        .i_raddr_a (ptr_add(r_head, ONE)),
        .i_raddr_b (ptr_sub(r_head, eff_r)),
        .o_rdata_a (rd_xf),
        .o_rdata_b (rd_yb)
    );

    sspmv_hist_ram #(
        .DEPTH (DEPTH),
        .WIDTH (ENT_W)
    ) u_ram_y (
        .i_clk     (i_clk),
        .i_we      (in_fire && write_vox),
        .i_waddr   (wp_next),
        .i_wdata   (in_entry),
        .i_re      (en_b),
        .i_raddr_a (ptr_add(r_head, eff_r)),
        .i_raddr_b (ptr_sub(r_head, eff_s)),
        .o_rdata_a (rd_yf),
        .o_rdata_b (rd_zb)
    );

    // ------------------------------------------------------------------
    // stage b: tap flags and newest-voxel bypass
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (en_b) begin
            r_b_valid <= in_fire && n_give;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_b && in_fire && n_give) begin
            r_b_last  <= give_flush && (r_pending == ONE);
            r_b_f     <= n_flags;
            r_b_near0 <= write_vox ? i_vox.vector_value : r_newest;
        end
    end

    always_comb begin
        term_xf = '0;
        term_yf = '0;
        term_zf = '0;
        term_xb = '0;
        term_yb = '0;
        term_zb = '0;
        if (rd_center[POS_NX] && r_b_f.xf) begin
            term_xf = r_b_f.xf0 ? ext(r_b_near0) : ext(ent_val(rd_xf));
        end
        if (rd_center[POS_NY] && r_b_f.yf) begin
            term_yf = r_b_f.yf0 ? ext(r_b_near0) : ext(ent_val(rd_yf));
        end
        if (rd_center[POS_NZ] && r_b_f.zf) begin
            term_zf = ext(r_b_near0);
        end
        if (rd_xb[POS_NX] && r_b_f.xb) begin
            term_xb = ext(ent_val(rd_xb));
        end
        if (rd_yb[POS_NY] && r_b_f.yb) begin
            term_yb = ext(ent_val(rd_yb));
        end
        if (rd_zb[POS_NZ] && r_b_f.zb) begin
            term_zb = ext(ent_val(rd_zb));
        end
        n_c_prod = ext(ent_val(rd_center)) * PROD_W'(rd_center[FLAG_W +: DIAG_W]);
        n_c_s1   = term_xf + term_yf + term_zf;
        n_c_s2   = term_xb + term_yb + term_zb;
    end

    // ------------------------------------------------------------------
    // stage c: diagonal product and neighbor sums
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (en_c) begin
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_c && r_b_valid) begin
            r_c_prod <= n_c_prod;
            r_c_s1   <= n_c_s1;
            r_c_s2   <= n_c_s2;
            r_c_last <= r_b_last;
        end
    end

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en_out) begin
            r_out_valid <= r_c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_out && r_c_valid) begin
            r_out_prod <= r_c_prod - r_c_s1 - r_c_s2;
            r_out_last <= r_c_last;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.product_value = r_out_prod;
    assign o_res.last_voxel    = r_out_last;

`ifndef ASSERT_OFF
    a_drain_owes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_draining |-> (r_pending != '0))
        else $error("draining with no result owed");

    a_idle_older: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pending == '0) |-> (r_older == '0))
        else $error("older count left over from a finished volume");

    a_last_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_b_valid && r_b_last) |-> (r_pending == '0))
        else $error("last item in flight while results still owed");

    a_z_tap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_b_valid && r_b_f.zf) |-> (r_b_f.xf && r_b_f.yf))
        else $error("forward z tap valid without nearer forward taps");
`endif

endmodule
